// ===== design/hrsp_pkg.sv =====
// hrsp_pkg: shared types and constants for the heading and range servo pulse control block
// used by every module under design/; no dependencies of its own

package hrsp_pkg;

	// request kinds
	typedef enum logic {
		OP_COMPASS = 1'b0,
		OP_RANGER  = 1'b1
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_TARGET_HEADING    = 2'd0,
		REG_STEERING_GAIN     = 2'd1,
		REG_DRIVE_GAIN        = 2'd2,
		REG_REACTION_DISTANCE = 2'd3
	} reg_idx_t;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 12;

	// reset values of the configuration registers
	localparam logic [11:0] RST_TARGET_HEADING    = 12'd2700;
	localparam logic [7:0]  RST_STEERING_GAIN     = 8'd25;
	localparam logic [7:0]  RST_DRIVE_GAIN        = 8'd25;
	localparam logic [7:0]  RST_REACTION_DISTANCE = 8'd60;

	// heading wrap
	localparam logic signed [12:0] HALF_TURN = 13'sd1800;
	localparam logic signed [12:0] FULL_TURN = 13'sd3600;

	// steering pulse, with bounds scaled by the gain divisor of 25
	localparam logic [11:0]        STEER_CENTRE     = 12'd2905;
	localparam logic [11:0]        STEER_LOW        = 12'd2315;
	localparam logic [11:0]        STEER_HIGH       = 12'd3395;
	localparam logic signed [21:0] STEER_CENTRE_X25 = 22'sd72625;
	localparam logic signed [21:0] STEER_LOW_X25    = 22'sd57875;
	localparam logic signed [21:0] STEER_OVER_X25   = 22'sd84900;
	// floor(d / 25) as (d * 41944) >> 20, exact for d below 43690
	localparam logic [30:0]        RECIP_25         = 31'd41944;
	localparam int unsigned        RECIP_25_SH      = 20;

	// drive pulse
	localparam logic [15:0] DRIVE_NEUTRAL   = 16'd2765;
	localparam logic [11:0] DRIVE_HIGH_BASE = 12'd3500;
	// the constant part of the reverse numerator
	localparam logic [14:0] REV_OFFSET      = 15'd17500;
	localparam logic [7:0]  LIGHT_LIMIT     = 8'd245;

	// floor(pot * 27 / 10) as (pot * 176958) >> 16
	localparam logic [25:0] RECIP_POT    = 26'd176958;
	localparam int unsigned RECIP_POT_SH = 16;
	// floor(range / 5) as (range * 52429) >> 18
	localparam logic [31:0] RECIP_5      = 32'd52429;
	localparam int unsigned RECIP_5_SH   = 18;
	// floor(w / 10) as (w * 26215) >> 18, exact for w below 43690
	localparam logic [29:0] RECIP_10     = 30'd26215;
	localparam int unsigned RECIP_10_SH  = 18;

	typedef struct packed {
		logic [11:0] target_heading;
		logic [7:0]  steering_gain;
		logic [7:0]  drive_gain;
		logic [7:0]  reaction_distance;
	} cfg_t;

	// pipeline stage enables
	typedef struct packed {
		logic s1_en;
		logic s2_en;
		logic s3_en;
		logic out_en;
	} pipe_ctl_t;

	// request as captured at the input
	typedef struct packed {
		op_t         op;
		logic [11:0] heading;
		logic [15:0] range_cm;
		logic [7:0]  light;
		logic [7:0]  speed_pot;
		logic        blink;
	} req_t;

	// after the front stage
	typedef struct packed {
		op_t                op;
		logic signed [11:0] err;
		logic               rev;
		logic               buz;
		logic [9:0]         speed_cap;
		logic [13:0]        range_q5;
		logic [9:0]         gain_rr;
		logic               near;
		logic [7:0]         shortfall;
	} front_t;

	// after the product stage
	typedef struct packed {
		op_t                op;
		logic signed [20:0] sprod;
		logic               rev;
		logic               buz;
		logic [15:0]        drive;
	} mid_t;

endpackage

// ===== design/hrsp_cfg.sv =====
// hrsp_cfg: configuration register file written through a plain write port
// depends on hrsp_pkg

module hrsp_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hrsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hrsp_pkg::CFG_DATA_W-1:0] cfg_data,
	output hrsp_pkg::cfg_t                   cfg
);

	hrsp_pkg::cfg_t cfg_q;

	// register writes, each register takes the low bits of the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_heading    <= hrsp_pkg::RST_TARGET_HEADING;
			cfg_q.steering_gain     <= hrsp_pkg::RST_STEERING_GAIN;
			cfg_q.drive_gain        <= hrsp_pkg::RST_DRIVE_GAIN;
			cfg_q.reaction_distance <= hrsp_pkg::RST_REACTION_DISTANCE;
		end else if (cfg_we) begin
			unique case (hrsp_pkg::reg_idx_t'(cfg_index))
				hrsp_pkg::REG_TARGET_HEADING:    cfg_q.target_heading    <= cfg_data;
				hrsp_pkg::REG_STEERING_GAIN:     cfg_q.steering_gain     <= cfg_data[7:0];
				hrsp_pkg::REG_DRIVE_GAIN:        cfg_q.drive_gain        <= cfg_data[7:0];
				hrsp_pkg::REG_REACTION_DISTANCE: cfg_q.reaction_distance <= cfg_data[7:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/hrsp_front.sv =====
// hrsp_front: input register and first stage (heading wrap, speed limit, range split by five)
// depends on hrsp_pkg

module hrsp_front (
	input  logic                clk,
	input  hrsp_pkg::pipe_ctl_t ctl,
	input  hrsp_pkg::cfg_t      cfg,
	input  logic                op,
	input  logic [11:0]         heading,
	input  logic [15:0]         range_cm,
	input  logic [7:0]          light,
	input  logic [7:0]          speed_pot,
	input  logic                blink,
	output hrsp_pkg::front_t    front_s2
);

	hrsp_pkg::req_t     req_s1;
	hrsp_pkg::front_t   front_d;
	logic signed [12:0] err_raw;
	logic signed [12:0] err_wrap;
	logic [25:0]        ms_full;
	logic [31:0]        rq_full;
	logic [13:0]        range_q5;
	logic [15:0]        five_rq;
	logic [2:0]         range_r5;
	logic [9:0]         gain_rr;

	// input register
	always_ff @(posedge clk) begin
		if (ctl.s1_en) begin
			req_s1.op        <= hrsp_pkg::op_t'(op);
			req_s1.heading   <= heading;
			req_s1.range_cm  <= range_cm;
			req_s1.light     <= light;
			req_s1.speed_pot <= speed_pot;
			req_s1.blink     <= blink;
		end
	end

	// heading error, wrapped once into plus or minus half a turn
	always_comb begin
		err_raw = $signed({1'b0, cfg.target_heading}) - $signed({1'b0, req_s1.heading});
		if (err_raw > hrsp_pkg::HALF_TURN) begin
			err_wrap = err_raw - hrsp_pkg::FULL_TURN;
		end else if (err_raw < -hrsp_pkg::HALF_TURN) begin
			err_wrap = err_raw + hrsp_pkg::FULL_TURN;
		end else begin
			err_wrap = err_raw;
		end
	end

	// speed limit and range split into quotient and remainder by five
	assign ms_full  = {18'h0, req_s1.speed_pot} * hrsp_pkg::RECIP_POT;
	assign rq_full  = {16'h0, req_s1.range_cm} * hrsp_pkg::RECIP_5;
	assign range_q5 = rq_full[hrsp_pkg::RECIP_5_SH +: 14];
	assign five_rq  = {range_q5, 2'b00} + {2'b00, range_q5};
	assign range_r5 = 3'(req_s1.range_cm - five_rq);

	// drive gain times the remainder, by shift and add
	always_comb begin
		case (range_r5)
			3'd1:    gain_rr = {2'b00, cfg.drive_gain};
			3'd2:    gain_rr = {1'b0, cfg.drive_gain, 1'b0};
			3'd3:    gain_rr = {1'b0, cfg.drive_gain, 1'b0} + {2'b00, cfg.drive_gain};
			3'd4:    gain_rr = {cfg.drive_gain, 2'b00};
			default: gain_rr = '0;
		endcase
	end

	// stage record
	always_comb begin
		front_d.op        = req_s1.op;
		front_d.err       = err_wrap[11:0];
		front_d.rev       = (req_s1.light > hrsp_pkg::LIGHT_LIMIT);
		front_d.buz       = (req_s1.light > hrsp_pkg::LIGHT_LIMIT) ? req_s1.blink : 1'b1;
		front_d.speed_cap = ms_full[hrsp_pkg::RECIP_POT_SH +: 10];
		front_d.range_q5  = range_q5;
		front_d.gain_rr   = gain_rr;
		front_d.near      = (req_s1.range_cm < {8'h00, cfg.reaction_distance});
		front_d.shortfall = cfg.reaction_distance - req_s1.range_cm[7:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.s2_en) begin
			front_s2 <= front_d;
		end
	end

endmodule

// ===== design/hrsp_mid.sv =====
// hrsp_mid: product stage (steering product, forward and reverse drive pulse)
// depends on hrsp_pkg

module hrsp_mid (
	input  logic                clk,
	input  hrsp_pkg::pipe_ctl_t ctl,
	input  hrsp_pkg::cfg_t      cfg,
	input  hrsp_pkg::front_t    front_s2,
	output hrsp_pkg::mid_t      mid_s3
);

	hrsp_pkg::mid_t     mid_d;
	logic signed [20:0] gain_x;
	logic signed [20:0] err_x;
	logic [11:0]        top;
	logic [11:0]        headroom;
	logic [15:0]        cut;
	logic [11:0]        fwd_drive;
	logic [21:0]        base;
	logic [11:0]        five_m;
	logic [14:0]        rem_num;
	logic [29:0]        rem_full;
	logic [11:0]        rem_q;
	logic [22:0]        rev_sum;
	logic [15:0]        rev_drive;

	// steering product, sign applied later against the direction
	assign gain_x = 21'($signed({1'b0, cfg.steering_gain}));
	assign err_x  = 21'($signed(front_s2.err));

	// forward: top speed less the shortfall penalty, floored at neutral
	assign top      = hrsp_pkg::DRIVE_HIGH_BASE - {2'b00, front_s2.speed_cap};
	assign headroom = top - hrsp_pkg::DRIVE_NEUTRAL[11:0];
	assign cut      = {8'h00, cfg.drive_gain} * {8'h00, front_s2.shortfall};

	always_comb begin
		if (!front_s2.near) begin
			fwd_drive = top;
		end else if (cut > {4'h0, headroom}) begin
			fwd_drive = hrsp_pkg::DRIVE_NEUTRAL[11:0];
		end else begin
			fwd_drive = top - cut[11:0];
		end
	end

	// reverse: gain times range quotient plus the small remainder term over ten
	assign base     = {14'h0, cfg.drive_gain} * {8'h00, front_s2.range_q5};
	assign five_m   = {front_s2.speed_cap, 2'b00} + {2'b00, front_s2.speed_cap};
	assign rem_num  = hrsp_pkg::REV_OFFSET + {4'h0, front_s2.gain_rr, 1'b0} - {3'h0, five_m};
	assign rem_full = {15'h0, rem_num} * hrsp_pkg::RECIP_10;
	assign rem_q    = rem_full[hrsp_pkg::RECIP_10_SH +: 12];
	assign rev_sum  = {1'b0, base} + {11'h0, rem_q};
	assign rev_drive = (|rev_sum[22:16]) ? 16'hFFFF : rev_sum[15:0];

	// stage record
	always_comb begin
		mid_d.op    = front_s2.op;
		mid_d.sprod = gain_x * err_x;
		mid_d.rev   = front_s2.rev;
		mid_d.buz   = front_s2.buz;
		mid_d.drive = front_s2.rev ? rev_drive : {4'h0, fwd_drive};
	end

	always_ff @(posedge clk) begin
		if (ctl.s3_en) begin
			mid_s3 <= mid_d;
		end
	end

endmodule

// ===== design/hrsp_state.sv =====
// hrsp_state: steering pulse finish and the state registers that also hold the result
// depends on hrsp_pkg

module hrsp_state (
	input  logic                clk,
	input  logic                arst_n,
	input  hrsp_pkg::pipe_ctl_t ctl,
	input  hrsp_pkg::mid_t      mid_s3,
	output logic [11:0]         steer_pulse,
	output logic [15:0]         drive_pulse,
	output logic                buzzer,
	output logic                going_forward
);

	logic               fwd_q;
	logic               buz_q;
	logic [11:0]        steer_q;
	logic [15:0]        drive_q;
	logic signed [21:0] sx;
	logic signed [21:0] num;
	logic signed [21:0] above_low;
	logic [14:0]        d;
	logic [30:0]        dq_full;
	logic [10:0]        dq;
	logic [11:0]        steer_next;

	// centre plus or minus the product, mirrored when reversing
	assign sx  = 22'($signed(mid_s3.sprod));
	assign num = fwd_q ? (hrsp_pkg::STEER_CENTRE_X25 + sx) : (hrsp_pkg::STEER_CENTRE_X25 - sx);

	// divide by 25 only inside the clamp window
	assign above_low = num - hrsp_pkg::STEER_LOW_X25;
	assign d         = above_low[14:0];
	assign dq_full   = {16'h0, d} * hrsp_pkg::RECIP_25;
	assign dq        = dq_full[hrsp_pkg::RECIP_25_SH +: 11];

	always_comb begin
		if (num < hrsp_pkg::STEER_LOW_X25) begin
			steer_next = hrsp_pkg::STEER_LOW;
		end else if (num >= hrsp_pkg::STEER_OVER_X25) begin
			steer_next = hrsp_pkg::STEER_HIGH;
		end else begin
			steer_next = hrsp_pkg::STEER_LOW + {1'b0, dq};
		end
	end

	// state update as each request leaves for the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q   <= 1'b0;
			buz_q   <= 1'b1;
			steer_q <= hrsp_pkg::STEER_CENTRE;
			drive_q <= hrsp_pkg::DRIVE_NEUTRAL;
		end else if (ctl.out_en) begin
			if (mid_s3.op == hrsp_pkg::OP_RANGER) begin
				fwd_q   <= !mid_s3.rev;
				buz_q   <= mid_s3.buz;
				drive_q <= mid_s3.drive;
			end else begin
				steer_q <= steer_next;
			end
		end
	end

	assign steer_pulse   = steer_q;
	assign drive_pulse   = drive_q;
	assign buzzer        = buz_q;
	assign going_forward = fwd_q;

endmodule

// ===== design/heading_range_servo_pulse_control_top.sv =====
// Heading and range servo pulse control. Takes one request per clock with valid/ready on
// both sides, unless out_ready stalls the output; each result is offered once its request
// has passed the input register and the three register stages behind it (front register,
// product register, state/result register). Compass requests update the steering pulse,
// ranger requests the direction, buzzer and drive pulse; every result carries all four
// current values. The state registers hold the result on the output; an item moves in
// only when the output is free or being taken. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while no request is in flight; the block does not check.
// depends on hrsp_pkg, hrsp_cfg, hrsp_front, hrsp_mid, hrsp_state

module heading_range_servo_pulse_control_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hrsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hrsp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             op,
	input  logic [11:0]                      heading,
	input  logic [15:0]                      range_cm,
	input  logic [7:0]                       light,
	input  logic [7:0]                       speed_pot,
	input  logic                             blink,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [11:0]                      steer_pulse,
	output logic [15:0]                      drive_pulse,
	output logic                             buzzer,
	output logic                             going_forward
);

	hrsp_pkg::cfg_t      cfg;
	hrsp_pkg::pipe_ctl_t ctl;
	hrsp_pkg::front_t    front_s2;
	hrsp_pkg::mid_t      mid_s3;
	logic                valid_s1;
	logic                valid_s2;
	logic                valid_s3;
	logic                out_valid_q;

	// stage enables, each stage moves when the one after has room
	always_comb begin
		ctl.out_en = valid_s3 && (!out_valid_q || out_ready);
		ctl.s3_en  = valid_s2 && (!valid_s3 || ctl.out_en);
		ctl.s2_en  = valid_s1 && (!valid_s2 || ctl.s3_en);
		ctl.s1_en  = in_valid && (!valid_s1 || ctl.s2_en);
	end

	assign in_ready = !valid_s1 || ctl.s2_en;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= ctl.s1_en || (valid_s1 && !ctl.s2_en);
			valid_s2    <= ctl.s2_en || (valid_s2 && !ctl.s3_en);
			valid_s3    <= ctl.s3_en || (valid_s3 && !ctl.out_en);
			out_valid_q <= ctl.out_en || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;

	hrsp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hrsp_front u_front (
		.clk       (clk),
		.ctl       (ctl),
		.cfg       (cfg),
		.op        (op),
		.heading   (heading),
		.range_cm  (range_cm),
		.light     (light),
		.speed_pot (speed_pot),
		.blink     (blink),
		.front_s2  (front_s2)
	);

	hrsp_mid u_mid (
		.clk      (clk),
		.ctl      (ctl),
		.cfg      (cfg),
		.front_s2 (front_s2),
		.mid_s3   (mid_s3)
	);

	hrsp_state u_state (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.mid_s3        (mid_s3),
		.steer_pulse   (steer_pulse),
		.drive_pulse   (drive_pulse),
		.buzzer        (buzzer),
		.going_forward (going_forward)
	);

endmodule
